// ===== rtl/core/bust_pkg.sv =====
// Shared constants and control types for the bounded unique set table.
`timescale 1ns / 1ps

package bust_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned LIMIT_W  = 7;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STS_W    = 3;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_DEL  = 2'd1;
  localparam logic [1:0] CMD_DUMP = 2'd2;

  localparam logic [STS_W-1:0] STS_DONE     = 3'd0;
  localparam logic [STS_W-1:0] STS_FULL     = 3'd1;
  localparam logic [STS_W-1:0] STS_PRESENT  = 3'd2;
  localparam logic [STS_W-1:0] STS_NOTFOUND = 3'd3;
  localparam logic [STS_W-1:0] STS_EMPTY    = 3'd4;
  localparam logic [STS_W-1:0] STS_ELEMENT  = 3'd5;

  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic             idx_inc;
    logic             wr_append;
    logic             wr_shift;
    logic             cnt_dec;
    logic             out_load;
    logic [STS_W-1:0] out_status;
    logic             out_sel_elem;
    logic             out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic is_full;
    logic idx_end;
    logic idx_last;
    logic match;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== rtl/core/bust_ctrl.sv =====
// Controller state machine that sequences add, delete and dump requests.
`timescale 1ns / 1ps

module bust_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [1:0]                in_command_i,
  output logic                      in_stall_o,
  input  bust_pkg::dp_status_t      stat_i,
  output bust_pkg::ctrl_cmd_t       cmd_o
);
  import bust_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SCAN_RD  = 8'b0000_0010,
    S_SCAN_CMP = 8'b0000_0100,
    S_SHIFT_RD = 8'b0000_1000,
    S_SHIFT_WR = 8'b0001_0000,
    S_DUMP_RD  = 8'b0010_0000,
    S_DUMP_OUT = 8'b0100_0000,
    S_RESP     = 8'b1000_0000
  } state_e;

  state_e           state_q, state_d;
  logic             del_q, del_d;
  logic [STS_W-1:0] resp_q, resp_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    del_d   = del_q;
    resp_d  = resp_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (in_command_i)
            CMD_ADD: begin
              del_d = 1'b0;
              if (stat_i.is_full) begin
                resp_d  = STS_FULL;
                state_d = S_RESP;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            CMD_DEL: begin
              del_d   = 1'b1;
              state_d = S_SCAN_RD;
            end
            CMD_DUMP: begin
              if (stat_i.count_zero) begin
                resp_d  = STS_EMPTY;
                state_d = S_RESP;
              end else begin
                state_d = S_DUMP_RD;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (stat_i.idx_end) begin
          if (del_q) begin
            resp_d = STS_NOTFOUND;
          end else begin
            cmd_o.wr_append = 1'b1;
            resp_d          = STS_DONE;
          end
          state_d = S_RESP;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (stat_i.match && !del_q) begin
          resp_d  = STS_PRESENT;
          state_d = S_RESP;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = stat_i.match ? S_SHIFT_RD : S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if (stat_i.idx_end) begin
          cmd_o.cnt_dec = 1'b1;
          resp_d        = STS_DONE;
          state_d       = S_RESP;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        state_d        = S_SHIFT_RD;
      end
      S_DUMP_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_status   = STS_ELEMENT;
          cmd_o.out_sel_elem = 1'b1;
          cmd_o.out_last     = stat_i.idx_last;
          if (stat_i.idx_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_DUMP_RD;
          end
        end
      end
      S_RESP: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = resp_q;
          cmd_o.out_last   = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      del_q   <= 1'b0;
      resp_q  <= STS_DONE;
    end else begin
      state_q <= state_d;
      del_q   <= del_d;
      resp_q  <= resp_d;
    end
  end

endmodule

// ===== rtl/core/bust_dp.sv =====
// Datapath: entry memory, count, limit register, scan index and result register.
`timescale 1ns / 1ps

module bust_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [bust_pkg::LIMIT_W-1:0]  cfg_data_i,
  input  logic signed [bust_pkg::DATA_W-1:0] in_value_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [bust_pkg::STS_W-1:0]    out_status_o,
  output logic signed [bust_pkg::DATA_W-1:0] out_element_o,
  output logic                          out_last_o,
  input  bust_pkg::ctrl_cmd_t           cmd_i,
  output bust_pkg::dp_status_t          stat_o
);
  import bust_pkg::*;

  logic [DATA_W-1:0]  mem [CAPACITY];
  logic [DATA_W-1:0]  rd_data_q;
  logic [DATA_W-1:0]  value_q;
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   idx_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [LIMIT_W-1:0] eff_limit;
  logic [CNT_W-1:0]   idx_m1;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [DATA_W-1:0]  wr_data;

  logic               out_valid_q;
  logic [STS_W-1:0]   out_status_q;
  logic [DATA_W-1:0]  out_element_q;
  logic               out_last_q;

  assign eff_limit = (limit_q > LIMIT_W'(CAPACITY)) ? LIMIT_W'(CAPACITY) : limit_q;
  assign idx_m1    = idx_q - CNT_W'(1);
  assign wr_en     = cmd_i.wr_append | cmd_i.wr_shift;
  assign wr_addr   = cmd_i.wr_append ? count_q[ADDR_W-1:0] : idx_m1[ADDR_W-1:0];
  assign wr_data   = cmd_i.wr_append ? value_q : rd_data_q;

  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.is_full    = (count_q >= CNT_W'(eff_limit));
  assign stat_o.idx_end    = (idx_q == count_q);
  assign stat_o.idx_last   = ((idx_q + CNT_W'(1)) == count_q);
  assign stat_o.match      = (rd_data_q == value_q);
  assign stat_o.out_busy   = out_valid_q & out_stall_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[idx_q[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= in_value_i;
    end
    if (cmd_i.out_load) begin
      out_status_q  <= cmd_i.out_status;
      out_element_q <= cmd_i.out_sel_elem ? rd_data_q : '0;
      out_last_q    <= cmd_i.out_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      limit_q     <= LIMIT_W'(64);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (cmd_i.wr_append) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CNT_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_element_o = out_element_q;
  assign out_last_o    = out_last_q;

endmodule

// ===== rtl/core/bounded_unique_set_table_unit.sv =====
// Top level of the bounded unique set table: controller, datapath and checks.
`timescale 1ns / 1ps

// Holds up to min(capacity_limit, 64) distinct signed 32-bit values in insertion
// order in a single-port entry memory with registered read. One request is
// worked at a time; in_stall_o is high from acceptance until its last result is
// loaded into the output register. Each stored entry visited takes a memory
// read, then a compare or a move; a dump reads each entry and then loads it
// into the output register, waiting while the output is stalled. Command 3
// is dropped with no result. The limit register is written through
// cfg_valid_i/cfg_data_i and resets to 64.
module bounded_unique_set_table_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bust_pkg::LIMIT_W-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          in_command_i,
  input  logic signed [bust_pkg::DATA_W-1:0]  in_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bust_pkg::STS_W-1:0]          out_status_o,
  output logic signed [bust_pkg::DATA_W-1:0]  out_element_o,
  output logic                                out_last_o
);
  import bust_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  assign cfg_ready_o = 1'b1;

  bust_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_command_i),
    .in_stall_o   (in_stall_o),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  bust_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .in_value_i    (in_value_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_status_o  (out_status_o),
    .out_element_o (out_element_o),
    .out_last_o    (out_last_o),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

`ifndef SYNTHESIS
  a_load_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !stat.out_busy)
    else $error("result register overwritten while stalled");

  a_append_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_append |-> !stat.is_full)
    else $error("append into a full table");

  a_dec_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cnt_dec |-> !stat.count_zero)
    else $error("count decrement on an empty table");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_command_i == CMD_ADD || in_command_i == CMD_DEL
     || in_command_i == CMD_DUMP)) |=> in_stall_o)
    else $error("new request taken before the current one finished");
`endif

endmodule

// ===== sim/tb_bounded_unique_set_table_unit.sv =====
// Self-checking testbench for the bounded unique set table unit.
`timescale 1ns / 1ps

module tb_bounded_unique_set_table_unit;
  import bust_pkg::*;

  localparam logic [1:0] CMD_UNUSED    = 2'd3;
  localparam int         SETTLE_CYCLES = 150;
  localparam int         CYCLE_LIMIT   = 4000000;
  localparam int         PHASE_ITEMS   = 25;

  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic [DATA_W-1:0] element;
    logic              last;
  } set_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [LIMIT_W-1:0]       cfg_data_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [1:0]               in_command_i;
  logic signed [DATA_W-1:0] in_value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [STS_W-1:0]         out_status_o;
  logic signed [DATA_W-1:0] out_element_o;
  logic                     out_last_o;

  logic [DATA_W-1:0] stored_values[$];
  int unsigned       limit_shadow;
  set_result_t       pending_results[$];
  int                err_cnt   = 0;
  int                cycle_cnt = 0;
  int                hold_len  = 0;
  bit                src_idle_en;
  bit                sink_idle_en;

  bounded_unique_set_table_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_command_i  (in_command_i),
    .in_value_i    (in_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_status_o  (out_status_o),
    .out_element_o (out_element_o),
    .out_last_o    (out_last_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void push_result(logic [STS_W-1:0] status, logic [DATA_W-1:0] element,
                                      logic last);
    set_result_t r;
    r.status  = status;
    r.element = element;
    r.last    = last;
    pending_results.push_back(r);
  endfunction

  function automatic void apply_set_request(logic [1:0] cmd, logic [DATA_W-1:0] val);
    int unsigned room;
    int          hit;
    room = (limit_shadow > CAPACITY) ? CAPACITY : limit_shadow;
    hit  = -1;
    foreach (stored_values[i])
      if (hit < 0 && stored_values[i] == val) hit = i;
    case (cmd)
      CMD_ADD: begin
        if (stored_values.size() >= room) begin
          push_result(STS_FULL, '0, 1'b1);
        end else if (hit >= 0) begin
          push_result(STS_PRESENT, '0, 1'b1);
        end else begin
          stored_values.push_back(val);
          push_result(STS_DONE, '0, 1'b1);
        end
      end
      CMD_DEL: begin
        if (hit >= 0) begin
          stored_values.delete(hit);
          push_result(STS_DONE, '0, 1'b1);
        end else begin
          push_result(STS_NOTFOUND, '0, 1'b1);
        end
      end
      CMD_DUMP: begin
        if (stored_values.size() == 0) begin
          push_result(STS_EMPTY, '0, 1'b1);
        end else begin
          foreach (stored_values[i])
            push_result(STS_ELEMENT, stored_values[i], i == stored_values.size() - 1);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned       r;
    logic [DATA_W-1:0] v;
    r = $urandom_range(0, 9);
    v = $urandom;
    if (r < 4 && stored_values.size() > 0) begin
      v = stored_values[$urandom_range(0, stored_values.size() - 1)];
    end else if (r < 7) begin
      case ($urandom_range(0, 7))
        0: v = 32'h8000_0000;
        1: v = 32'h7FFF_FFFF;
        2: v = 32'h0000_0000;
        3: v = 32'hFFFF_FFFF;
        4: v = 32'h0000_0001;
        5: v = 32'h8000_0001;
        6: v = 32'h0000_0100;
        default: v = 32'h1234_5678;
      endcase
    end
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("ERROR %0t: %s got %h want %h", $time, what, got, want);
    err_cnt++;
  endtask

  task automatic send_request(logic [1:0] cmd, logic [DATA_W-1:0] val);
    int gap;
    gap = 0;
    if (src_idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    apply_set_request(cmd, val);
    in_valid_i   <= 1'b1;
    in_command_i <= cmd;
    in_value_i   <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_results;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] lim);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= lim;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    limit_shadow = 32'(lim);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic fill_table(int unsigned target);
    while (stored_values.size() < target) send_request(CMD_ADD, $urandom);
  endtask

  task automatic test_empty_table;
    send_request(CMD_DUMP, 32'h0000_0000);
    send_request(CMD_DEL, 32'h7FFF_FFFF);
    send_request(CMD_UNUSED, 32'hDEAD_BEEF);
    send_request(CMD_DUMP, 32'hFFFF_FFFF);
  endtask

  task automatic test_value_extremes;
    send_request(CMD_ADD, 32'h8000_0000);
    send_request(CMD_ADD, 32'h7FFF_FFFF);
    send_request(CMD_ADD, 32'h0000_0000);
    send_request(CMD_ADD, 32'hFFFF_FFFF);
    send_request(CMD_ADD, 32'h0000_0001);
    send_request(CMD_ADD, 32'h7FFF_FFFF);
    send_request(CMD_ADD, 32'h8000_0000);
    send_request(CMD_ADD, 32'hFFFF_FFFE);
    send_request(CMD_DUMP, 32'h0000_0000);
    send_request(CMD_DEL, 32'h0000_0000);
    send_request(CMD_DEL, 32'h8000_0000);
    send_request(CMD_DEL, 32'hFFFF_FFFE);
    send_request(CMD_DEL, 32'h1234_5678);
    send_request(CMD_UNUSED, 32'h7FFF_FFFF);
    send_request(CMD_DUMP, 32'h8000_0000);
  endtask

  task automatic test_capacity_limits;
    write_limit(7'd127);
    fill_table(CAPACITY);
    send_request(CMD_ADD, 32'h5555_AAAA);
    send_request(CMD_DUMP, 32'h0000_0000);
    write_limit(7'd64);
    send_request(CMD_ADD, 32'hAAAA_5555);
    write_limit(7'd3);
    send_request(CMD_ADD, 32'h0F0F_0F0F);
    send_request(CMD_DEL, stored_values[10]);
    send_request(CMD_DUMP, 32'h0000_0000);
    while (stored_values.size() > 0)
      send_request(CMD_DEL, stored_values[$urandom_range(0, stored_values.size() - 1)]);
    write_limit(7'd1);
    send_request(CMD_ADD, 32'h0000_00A5);
    send_request(CMD_ADD, 32'h0000_005A);
    send_request(CMD_ADD, 32'h0000_00A5);
    write_limit(7'd0);
    send_request(CMD_ADD, 32'h0000_005A);
    send_request(CMD_DUMP, 32'h0000_0000);
    send_request(CMD_DEL, 32'h0000_00A5);
    send_request(CMD_ADD, 32'h0000_00A5);
    send_request(CMD_DUMP, 32'h0000_0000);
  endtask

  task automatic test_backpressure;
    write_limit(7'd64);
    fill_table(24);
    hold_len = 400;
    send_request(CMD_DUMP, 32'h0000_0000);
    send_request(CMD_ADD, $urandom);
    send_request(CMD_DUMP, 32'h0000_0000);
    send_request(CMD_DEL, stored_values[0]);
    send_request(CMD_DUMP, 32'h0000_0000);
    send_request(CMD_ADD, stored_values[5]);
    drain_results();
    hold_len = 250;
    send_request(CMD_DEL, stored_values[stored_values.size() - 1]);
    send_request(CMD_DUMP, 32'h0000_0000);
    send_request(CMD_DEL, 32'h1357_9BDF);
    drain_results();
  endtask

  task automatic test_random_traffic;
    logic [LIMIT_W-1:0] phase_limit[5];
    int                 done_items;
    int unsigned        r;
    phase_limit[0] = LIMIT_W'($urandom_range(1, 127));
    phase_limit[1] = 7'd64;
    phase_limit[2] = 7'd2;
    phase_limit[3] = 7'd127;
    phase_limit[4] = LIMIT_W'($urandom_range(1, 63));
    for (int p = 0; p < 5; p++) begin
      write_limit(phase_limit[p]);
      if (p == 4) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end
      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          send_request(CMD_ADD, pick_value());
        end else if (r < 80) begin
          send_request(CMD_DEL, pick_value());
        end else if (r < 96) begin
          send_request(CMD_DUMP, $urandom);
        end else begin
          send_request(CMD_UNUSED, $urandom);
          done_items--;
        end
        done_items++;
      end
    end
  endtask

  initial begin : sink_drive
    int run_left;
    run_left    = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_len > 0) begin
        out_stall_i <= 1'b1;
        hold_len--;
      end else if (!sink_idle_en) begin
        out_stall_i <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        run_left = $urandom_range(1, 14) - 1;
      end else begin
        out_stall_i <= 1'b0;
        run_left = $urandom_range(1, 20) - 1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    set_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected, element", out_element_o, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_status_o !== want.status)
          report_mismatch("status", DATA_W'(out_status_o), DATA_W'(want.status));
        if (out_element_o !== want.element)
          report_mismatch("element", out_element_o, want.element);
        if (out_last_o !== want.last)
          report_mismatch("last", DATA_W'(out_last_o), DATA_W'(want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    in_command_i = CMD_ADD;
    in_value_i   = '0;
    limit_shadow = 64;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_table();
    test_value_extremes();
    test_capacity_limits();
    test_backpressure();
    test_random_traffic();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== bounded_unique_set_table_unit.f =====
rtl/core/bust_pkg.sv
rtl/core/bust_ctrl.sv
rtl/core/bust_dp.sv
rtl/core/bounded_unique_set_table_unit.sv
sim/tb_bounded_unique_set_table_unit.sv
